// ----- rtl/ci_tpdu_deframer_poller_unit_defines.svh -----
// Assertion macros used by the checker file of the TPDU deframer and poller.
// No dependencies; included by bare file name.
`ifndef CI_TPDU_DEFRAMER_POLLER_UNIT_DEFINES_SVH
`define CI_TPDU_DEFRAMER_POLLER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define CTDP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CTDP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ctdp_pkg.sv -----
// Package for the TPDU deframer and poller: phase and kind codes, tag constants,
// and the structs passed between the parser, the poll controller and the top level.
// No dependencies.
package ctdp_pkg;

   localparam int unsigned MAX_BUFFER = 1024;
   localparam int unsigned BLEN_W     = 11;

   typedef enum logic [2:0] {
      PH_SKIP1     = 3'd0,
      PH_SKIP2     = 3'd1,
      PH_TAG       = 3'd2,
      PH_LEN_FIRST = 3'd3,
      PH_LEN_EXT   = 3'd4,
      PH_CONN      = 3'd5,
      PH_PAYLOAD   = 3'd6,
      PH_DROP      = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_BYTE  = 3'd1,
      KIND_END   = 3'd2,
      KIND_DLAST = 3'd3,
      KIND_RCV   = 3'd4,
      KIND_ERR   = 3'd5
   } kind_type;

   localparam logic [1:0] FUNC_RX_BYTE    = 2'd0;
   localparam logic [1:0] FUNC_WR_TICK    = 2'd1;
   localparam logic [1:0] FUNC_MSG_QUEUED = 2'd2;

   localparam logic [7:0] TAG_SB        = 8'h80;
   localparam logic [7:0] TAG_DLAST     = 8'hA0;
   localparam logic [7:0] TAG_DMORE     = 8'hA1;
   localparam logic [7:0] LEN_ONE_EXT   = 8'h81;
   localparam logic [7:0] LEN_TWO_EXT   = 8'h82;
   localparam logic [2:0] POLL_LIMIT    = 3'd5;

   // Events from the byte parser that touch the poll flags.
   typedef struct packed {
      logic clear_enable;
      logic sb_rcv;
      logic sb_last;
   } poll_evt_type;

   // Parser side of one result.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload_byte;
      logic        apdu_end;
      logic [7:0]  conn_id;
      logic [7:0]  frame_tag;
   } parse_rsp_type;

endpackage

// ----- rtl/ci_tpdu_deframer_poller_unit.sv -----
// Top level of the common-interface TPDU deframer and poll controller.
// Depends on ctdp_pkg, ctdp_parser and ctdp_poller.
//
// Returns exactly one result transaction for each transaction it takes. A request
// is captured in an input register; once the result slot is free, the parser and
// poll controller update their state and the result is written to an output
// register, so throughput is one transaction per clock while nothing stalls.
// The input register stays free to accept while a finished result waits on
// rsp_stall; only when both registers are full does req_stall rise.
// Received bytes (func 0) walk a buffer: two header bytes are skipped, then each
// TPDU is tag, 1..3 byte length, connection id and payload. Data-more/data-last
// payload bytes come out as kind 1, with apdu_end on the last byte of an APDU;
// length and truncation faults give kind 5 and drop the rest of the buffer.
// A byte with first_of_buffer set restarts parsing from the header. Write-ready
// ticks (func 1) step the poll counter and may request a data-last poll (kind 3)
// or an RCV frame (kind 4), one per tick. func 2 cancels pending polling.
// conn_id and the tag output always show the connection and tag after the
// transaction.
module ci_tpdu_deframer_poller_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [7:0]                  req_rx_byte,
   input  logic                        req_first_of_buffer,
   input  logic [ctdp_pkg::BLEN_W-1:0] req_buffer_length,
   input  logic                        req_queue_empty,
   input  logic                        req_menu_open,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_kind,
   output logic [7:0]                  rsp_payload_byte,
   output logic                        rsp_apdu_end,
   output logic [7:0]                  rsp_conn_id,
   output logic [7:0]                  rsp_frame_tag
);
   import ctdp_pkg::*;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [1:0]        func_ff;
   logic [7:0]        rx_byte_ff;
   logic              first_ff;
   logic [BLEN_W-1:0] blen_ff;
   logic              qe_ff;
   logic              menu_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   kind_type          kind_ff, kind_in;
   logic [7:0]        pb_ff;
   logic              end_ff;
   logic [7:0]        conn_ff;
   logic [7:0]        tag_ff;

   logic              advance;
   logic              req_take;
   parse_rsp_type     parse_rsp;
   poll_evt_type      evt;
   kind_type          poll_kind;

   // the item in the input register moves on when the result slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0
                                                                        : out_valid_ff);

   ctdp_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .func            (func_ff),
      .rx_byte         (rx_byte_ff),
      .first_of_buffer (first_ff),
      .buffer_length   (blen_ff),
      .rsp             (parse_rsp),
      .evt             (evt)
   );

   ctdp_poller u_poller (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .func        (func_ff),
      .queue_empty (qe_ff),
      .menu_open   (menu_ff),
      .evt         (evt),
      .poll_kind   (poll_kind)
   );

   // parser only reports on received bytes, poller only on ticks
   assign kind_in = (parse_rsp.kind != KIND_NONE) ? parse_rsp.kind : poll_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff    <= req_func;
         rx_byte_ff <= req_rx_byte;
         first_ff   <= req_first_of_buffer;
         blen_ff    <= req_buffer_length;
         qe_ff      <= req_queue_empty;
         menu_ff    <= req_menu_open;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         kind_ff <= kind_in;
         pb_ff   <= parse_rsp.payload_byte;
         end_ff  <= parse_rsp.apdu_end;
         conn_ff <= parse_rsp.conn_id;
         tag_ff  <= parse_rsp.frame_tag;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_payload_byte = pb_ff;
   assign rsp_apdu_end     = end_ff;
   assign rsp_conn_id      = conn_ff;
   assign rsp_frame_tag    = tag_ff;

endmodule

// ----- rtl/ctdp_poller.sv -----
// Poll controller: status flags, poll enable and the write-ready poll counter.
// Depends on ctdp_pkg.
module ctdp_poller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [1:0]            func,
   input  logic                  queue_empty,
   input  logic                  menu_open,
   input  ctdp_pkg::poll_evt_type evt,
   output ctdp_pkg::kind_type    poll_kind
);
   import ctdp_pkg::*;

   logic       last_ff, last_in;
   logic       rcv_ff, rcv_in;
   logic       pe_ff, pe_in;
   logic [2:0] pc_ff, pc_in;
   logic       pe_set;

   always_comb begin
      last_in   = last_ff;
      rcv_in    = rcv_ff;
      pe_in     = pe_ff;
      pc_in     = pc_ff;
      poll_kind = KIND_NONE;
      pe_set    = pe_ff | (queue_empty & (rcv_ff | menu_open | (pc_ff > POLL_LIMIT)));
      unique case (func)
         FUNC_RX_BYTE: begin
            if (evt.clear_enable) pe_in = 1'b0;
            if (evt.sb_rcv) begin
               pe_in   = 1'b0;
               rcv_in  = 1'b1;
               last_in = 1'b0;
            end
            if (evt.sb_last) last_in = 1'b1;
         end
         FUNC_WR_TICK: begin
            pc_in = (pc_ff <= POLL_LIMIT) ? pc_ff + 3'd1 : 3'd0;
            // data-last poll wins; a pending RCV waits for a later tick
            if (queue_empty && pe_set && last_ff) begin
               pe_in     = 1'b0;
               last_in   = 1'b0;
               poll_kind = KIND_DLAST;
            end else if (queue_empty && pe_set && rcv_ff) begin
               pe_in     = 1'b0;
               rcv_in    = 1'b0;
               poll_kind = KIND_RCV;
            end else begin
               pe_in = pe_set;
            end
         end
         FUNC_MSG_QUEUED: pe_in = 1'b0;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
         rcv_ff  <= 1'b0;
         pe_ff   <= 1'b0;
         pc_ff   <= 3'd0;
      end else if (advance) begin
         last_ff <= last_in;
         rcv_ff  <= rcv_in;
         pe_ff   <= pe_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

// ----- rtl/ctdp_parser.sv -----
// Byte parser: header skip, TPDU tag, ASN.1 length, connection id and payload.
// Depends on ctdp_pkg.
module ctdp_parser (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [1:0]                   func,
   input  logic [7:0]                   rx_byte,
   input  logic                         first_of_buffer,
   input  logic [ctdp_pkg::BLEN_W-1:0]  buffer_length,
   output ctdp_pkg::parse_rsp_type      rsp,
   output ctdp_pkg::poll_evt_type       evt
);
   import ctdp_pkg::*;

   phase_type         phase_ff, phase_in, phase_cur;
   logic [BLEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic [7:0]        tag_ff, tag_in;
   logic [15:0]       len_ff, len_in;
   logic [1:0]        len_left_ff, len_left_in, len_left_cur, len_left_dec;
   logic [15:0]       pay_left_ff, pay_left_in, pay_cur, pay_dec;
   logic              chain_ff, chain_in, chain_new;
   logic [7:0]        conn_ff, conn_in;

   logic [BLEN_W-1:0] blen_clamped, rem, after;
   logic [15:0]       len_first, len_ext, len_m1;
   logic              first_ok, ext_ok, firstp, lastp;

   assign blen_clamped = (32'(buffer_length) > MAX_BUFFER) ? BLEN_W'(MAX_BUFFER)
                                                          : buffer_length;
   assign len_first = {8'd0, rx_byte};
   assign len_ext   = {len_ff[7:0], rx_byte};
   assign len_m1    = len_ff - 16'd1;

   always_comb begin
      phase_cur     = phase_ff;
      len_left_cur  = len_left_ff;
      pay_cur       = pay_left_ff;
      rem           = bytes_left_ff;
      evt           = '0;
      if (func == FUNC_RX_BYTE && first_of_buffer) begin
         phase_cur        = PH_SKIP1;
         len_left_cur     = 2'd0;
         pay_cur          = 16'd0;
         rem              = blen_clamped;
         evt.clear_enable = 1'b1;
      end
      after        = rem - BLEN_W'(1);
      first_ok     = (len_first != 16'd0) && (len_first <= 16'(after));
      ext_ok       = (len_ext != 16'd0) && (len_ext <= 16'(after));
      len_left_dec = (len_left_cur != 2'd0) ? len_left_cur - 2'd1 : 2'd0;
      pay_dec      = pay_cur - 16'd1;
      firstp       = (pay_cur == len_m1);
      lastp        = (pay_dec == 16'd0);
      chain_new    = (tag_ff == TAG_DMORE) ? 1'b1 : chain_ff;

      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      tag_in        = tag_ff;
      len_in        = len_ff;
      len_left_in   = len_left_ff;
      pay_left_in   = pay_left_ff;
      chain_in      = chain_ff;
      conn_in       = conn_ff;
      rsp.kind         = KIND_NONE;
      rsp.payload_byte = 8'd0;
      rsp.apdu_end     = 1'b0;

      if (func == FUNC_RX_BYTE) begin
         phase_in      = phase_cur;
         len_left_in   = len_left_cur;
         pay_left_in   = pay_cur;
         bytes_left_in = rem;
         if (rem != '0) begin
            bytes_left_in = after;
            unique case (phase_cur)
               PH_SKIP1: phase_in = PH_SKIP2;
               PH_SKIP2: phase_in = PH_TAG;
               PH_TAG: begin
                  tag_in = rx_byte;
                  if (rem < BLEN_W'(2)) begin
                     rsp.kind = KIND_ERR;
                     phase_in = PH_DROP;
                  end else begin
                     phase_in = PH_LEN_FIRST;
                  end
               end
               PH_LEN_FIRST: begin
                  priority if (!rx_byte[7]) begin
                     len_in   = len_first;
                     phase_in = first_ok ? PH_CONN : PH_DROP;
                     rsp.kind = first_ok ? KIND_NONE : KIND_ERR;
                  end else if (rx_byte == LEN_ONE_EXT && rem >= BLEN_W'(2)) begin
                     len_in      = 16'd0;
                     len_left_in = 2'd1;
                     phase_in    = PH_LEN_EXT;
                  end else if (rx_byte == LEN_TWO_EXT && rem >= BLEN_W'(3)) begin
                     len_in      = 16'd0;
                     len_left_in = 2'd2;
                     phase_in    = PH_LEN_EXT;
                  end else begin
                     rsp.kind = KIND_ERR;
                     phase_in = PH_DROP;
                  end
               end
               PH_LEN_EXT: begin
                  len_in      = len_ext;
                  len_left_in = len_left_dec;
                  if (len_left_dec == 2'd0) begin
                     phase_in = ext_ok ? PH_CONN : PH_DROP;
                     rsp.kind = ext_ok ? KIND_NONE : KIND_ERR;
                  end
               end
               PH_CONN: begin
                  conn_in     = rx_byte;
                  pay_left_in = len_m1;
                  chain_in    = chain_new;
                  if (len_m1 == 16'd0) begin
                     // empty data-last only matters when it closes a chain
                     if (tag_ff == TAG_DLAST && chain_new) begin
                        rsp.kind     = KIND_END;
                        rsp.apdu_end = 1'b1;
                        chain_in     = 1'b0;
                     end
                     phase_in = PH_TAG;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  if (pay_cur == 16'd0) begin
                     phase_in = PH_TAG;
                  end else begin
                     pay_left_in = pay_dec;
                     if (tag_ff == TAG_DMORE) begin
                        rsp.kind         = KIND_BYTE;
                        rsp.payload_byte = rx_byte;
                     end else if (tag_ff == TAG_DLAST) begin
                        rsp.kind         = KIND_BYTE;
                        rsp.payload_byte = rx_byte;
                        if (lastp) begin
                           rsp.apdu_end = 1'b1;
                           chain_in     = 1'b0;
                        end
                     end else if (tag_ff == TAG_SB && firstp) begin
                        evt.sb_rcv  = rx_byte[7];
                        evt.sb_last = !rx_byte[7];
                     end
                     if (lastp) phase_in = PH_TAG;
                  end
               end
               PH_DROP: ;
               default: ;
            endcase
         end
      end
      rsp.conn_id   = conn_in;
      rsp.frame_tag = tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SKIP1;
         bytes_left_ff <= '0;
         tag_ff        <= 8'd0;
         len_ff        <= 16'd0;
         len_left_ff   <= 2'd0;
         pay_left_ff   <= 16'd0;
         chain_ff      <= 1'b0;
         conn_ff       <= 8'd0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         tag_ff        <= tag_in;
         len_ff        <= len_in;
         len_left_ff   <= len_left_in;
         pay_left_ff   <= pay_left_in;
         chain_ff      <= chain_in;
         conn_ff       <= conn_in;
      end
   end

endmodule

// ----- rtl/ctdp_checker.sv -----
// Port-level checker for the TPDU deframer and poller, bound to the top level.
// Depends on ctdp_pkg and ci_tpdu_deframer_poller_unit_defines.svh.
`include "ci_tpdu_deframer_poller_unit_defines.svh"

module ctdp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_apdu_end,
   input logic [7:0] rsp_conn_id,
   input logic [7:0] rsp_frame_tag
);
   import ctdp_pkg::*;

   // result register comes up empty after reset
   `CTDP_ASSERT_NEXT(a_empty_after_reset, clock, 1'b0, reset, !rsp_valid,
                     "result valid after reset")

   // payload byte is zero unless a payload transaction is shown
   `CTDP_ASSERT_SAME(a_payload_zero, clock, reset, rsp_valid && rsp_kind != KIND_BYTE,
                     rsp_payload_byte == 8'd0, "payload byte set on non-payload result")

   // APDU end only with a payload byte or an end marker
   `CTDP_ASSERT_SAME(a_end_kind, clock, reset, rsp_valid && rsp_apdu_end,
                     rsp_kind == KIND_BYTE || rsp_kind == KIND_END, "apdu end on wrong kind")

   // a stalled result holds
   `CTDP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_kind) && $stable(rsp_payload_byte) && $stable(rsp_conn_id) && $stable(rsp_frame_tag),
                     "stalled result changed")

   // input only backs up behind a stalled result
   `CTDP_ASSERT_SAME(a_stall_full, clock, reset, req_stall, rsp_valid && rsp_stall,
                     "input stalled with result slot free")

endmodule

bind ci_tpdu_deframer_poller_unit ctdp_checker u_ctdp_checker (.*);
